/* rtl/core/shell_command_line_assembler_top_assert.svh */
// Assertion macros shared by the command line assembler checkers.
`ifndef SHELL_COMMAND_LINE_ASSEMBLER_TOP_ASSERT_SVH
`define SHELL_COMMAND_LINE_ASSEMBLER_TOP_ASSERT_SVH

// Implication in the same cycle, sampled on clk, disabled while arst_n is low.
`define SCLA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, sampled on clk, disabled while arst_n is low.
`define SCLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/scla_pkg.sv */
// Types and constants shared by the command line assembler modules.
`timescale 1ns / 1ps
package scla_pkg;

	localparam int POS_W = 6;

	localparam logic OPC_RX_BYTE   = 1'b0;
	localparam logic OPC_LINK_IDLE = 1'b1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CTRL_WS_HI = 8'h0D;
	localparam logic [7:0] CH_PRINT_LO   = 8'h21;
	localparam logic [7:0] CH_PRINT_HI   = 8'h7E;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_PROC,
		MODE_QUOTE,
		MODE_DISCARD
	} mode_t;

	typedef enum logic [1:0] {
		KIND_LINE,
		KIND_BAD_BYTE,
		KIND_QUOTE_EOL,
		KIND_OVERFLOW
	} kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_DRAIN
	} bk_state_t;

	// One command for the back end: an error, or a line of count bytes.
	typedef struct packed {
		kind_t             kind;
		logic [POS_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic  valid;
		cmd_t  cmd;
	} cmd_slot_t;

endpackage

/* rtl/core/scla_ram.sv */
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module scla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/scla_front.sv */
// Front end: accepts bytes, tracks the parse mode and fills the line store.
`timescale 1ns / 1ps
module scla_front
	import scla_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,
	input  logic [0:0]                           s_tuser,
	input  logic                                 fifo_full,
	input  logic                                 line_busy,
	output cmd_slot_t                            push,
	output logic                                 ram_we,
	output logic [$clog2(LINE_BUFFER_BYTES)-1:0] ram_waddr,
	output logic [7:0]                           ram_wdata
);

	localparam int FW = $clog2(LINE_BUFFER_BYTES);

	mode_t          mode_q, mode_d, new_mode;
	logic [FW-1:0]  fill_q, fill_d, line_len;
	logic [7:0]     last_q, last_d, prev_q, prev_d;
	logic [7:0]     ch;
	logic           accept, eol, ws, gr, store;

	// A finished line must leave the store before the next one is built.
	assign s_tready = !fifo_full && !line_busy;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		mode_d = mode_q;
		fill_d = fill_q;
		last_d = last_q;
		prev_d = prev_q;
		new_mode = mode_q;
		line_len = fill_q;
		ch = s_tdata;
		store = 1'b0;
		push.valid = 1'b0;
		push.cmd.kind = KIND_LINE;
		push.cmd.count = '0;
		eol = (s_tdata == CH_LF) || (s_tdata == CH_CR);
		ws = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CTRL_WS_HI));
		gr = (s_tdata >= CH_PRINT_LO) && (s_tdata <= CH_PRINT_HI);

		if (accept) begin
			if (s_tuser[0] == OPC_LINK_IDLE) begin
				mode_d = MODE_START;
				fill_d = '0;
			end else if (mode_q == MODE_DISCARD) begin
				if (eol) begin
					mode_d = MODE_START;
				end
			end else if (!ws && !gr) begin
				push.valid = 1'b1;
				push.cmd.kind = KIND_BAD_BYTE;
				mode_d = MODE_DISCARD;
				fill_d = '0;
			end else if (eol) begin
				if (mode_q == MODE_QUOTE) begin
					push.valid = 1'b1;
					push.cmd.kind = KIND_QUOTE_EOL;
				end else if (mode_q != MODE_START) begin
					if ((fill_q != '0) && (last_q == CH_SPACE)) begin
						line_len = fill_q - 1'b1;
					end
					if (line_len != '0) begin
						push.valid = 1'b1;
						push.cmd.count = POS_W'(line_len);
					end
				end
				mode_d = MODE_START;
				fill_d = '0;
			end else begin
				store = 1'b1;
				if (ws) begin
					if (mode_q == MODE_START) begin
						store = 1'b0;
					end else if (mode_q != MODE_QUOTE) begin
						if ((fill_q != '0) && (last_q == CH_SPACE)) begin
							store = 1'b0;
						end
						ch = CH_SPACE;
					end
				end
				if (store && (ch == CH_QUOTE)) begin
					if (mode_q == MODE_QUOTE) begin
						if ((fill_q != '0) && (last_q == CH_QUOTE)) begin
							// Empty quote pair: take back the opening quote.
							store = 1'b0;
							fill_d = fill_q - 1'b1;
							last_d = prev_q;
							mode_d = (fill_q != FW'(1)) ? MODE_PROC : MODE_START;
						end else begin
							new_mode = (fill_q != '0) ? MODE_PROC : MODE_START;
						end
					end else begin
						new_mode = MODE_QUOTE;
					end
				end
				if (store) begin
					if (fill_q >= FW'(LINE_BUFFER_BYTES - 1)) begin
						push.valid = 1'b1;
						push.cmd.kind = KIND_OVERFLOW;
						mode_d = MODE_DISCARD;
						fill_d = '0;
						store = 1'b0;
					end else begin
						fill_d = fill_q + 1'b1;
						last_d = ch;
						prev_d = last_q;
						mode_d = (new_mode == MODE_START) ? MODE_PROC : new_mode;
					end
				end
			end
		end
	end

	assign ram_we = store;
	assign ram_waddr = fill_q;
	assign ram_wdata = ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			fill_q <= '0;
		end else begin
			mode_q <= mode_d;
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		prev_q <= prev_d;
	end

endmodule

/* rtl/core/scla_cmd_fifo.sv */
// Two entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module scla_cmd_fifo
	import scla_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_slot_t push,
	input  logic      pop,
	output cmd_slot_t head,
	output logic      full,
	output logic      has_line
);

	cmd_t  mem_q [2];
	logic  vld_q [2];
	logic  wr_ptr_q, rd_ptr_q;

	assign head.valid = vld_q[rd_ptr_q];
	assign head.cmd = mem_q[rd_ptr_q];
	assign full = vld_q[0] && vld_q[1];

	always_comb begin
		has_line = 1'b0;
		for (int i = 0; i < 2; i++) begin
			if (vld_q[i] && (mem_q[i].kind == KIND_LINE)) begin
				has_line = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
			vld_q[1] <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push.valid && !full) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && head.valid) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && !full) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

/* rtl/core/scla_back.sv */
// Back end: turns queued commands into result items, reading lines from the store.
`timescale 1ns / 1ps
module scla_back
	import scla_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cmd_slot_t                            head,
	output logic                                 pop,
	output logic                                 draining,
	output logic                                 ram_re,
	output logic [$clog2(LINE_BUFFER_BYTES)-1:0] ram_raddr,
	input  logic [7:0]                           ram_rdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [1:0]                           m_tuser,
	output logic [7:0]                           m_byte,
	output logic [POS_W-1:0]                     m_pos,
	output logic                                 m_tlast
);

	localparam int FW = $clog2(LINE_BUFFER_BYTES);

	bk_state_t         state_q, state_d;
	logic [POS_W-1:0]  rd_idx_q, cnt_q, pos_s1;
	logic              in_flight_s1, last_s1;
	logic              out_valid_q, out_last_q;
	kind_t             out_kind_q;
	logic [7:0]        out_byte_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              load_ok, load_line, load_err, issue, start_line, issue_last;

	always_comb begin
		state_d = state_q;
		load_ok = !out_valid_q || m_tready;
		load_line = in_flight_s1 && load_ok;
		start_line = 1'b0;
		load_err = 1'b0;
		issue = 1'b0;
		issue_last = (rd_idx_q == cnt_q - 1'b1);
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid && (head.cmd.kind == KIND_LINE)) begin
					start_line = 1'b1;
					state_d = BK_DRAIN;
				end else if (head.valid && !in_flight_s1 && load_ok) begin
					load_err = 1'b1;
				end
			end
			BK_DRAIN: begin
				if (!in_flight_s1 || load_line) begin
					issue = 1'b1;
					if (issue_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign pop = start_line || load_err;
	assign draining = (state_q == BK_DRAIN);
	assign ram_re = issue;
	assign ram_raddr = rd_idx_q[FW-1:0];

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_kind_q;
	assign m_byte = out_byte_q;
	assign m_pos = out_pos_q;
	assign m_tlast = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			in_flight_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			in_flight_s1 <= issue || (in_flight_s1 && !load_line);
			if (load_line || load_err) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_line) begin
			rd_idx_q <= '0;
			cnt_q <= head.cmd.count;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (issue) begin
			pos_s1 <= rd_idx_q;
			last_s1 <= issue_last;
		end
		if (load_line) begin
			out_kind_q <= KIND_LINE;
			out_byte_q <= ram_rdata;
			out_pos_q <= pos_s1;
			out_last_q <= last_s1;
		end else if (load_err) begin
			out_kind_q <= head.cmd.kind;
			out_byte_q <= '0;
			out_pos_q <= '0;
			out_last_q <= 1'b1;
		end
	end

endmodule

/* rtl/core/shell_command_line_assembler_top.sv */
// Top level of the serial console command line assembler.
// Usage:
// Console bytes enter on the slave stream, one item per byte, with tuser set to 0.
// An item with tuser set to 1 reports that the link went inactive: the parser
// returns to its start mode and forgets the partial line, with no result.
// Result items leave on the master stream. tuser gives the kind (line byte or one
// of three errors), tdata the line byte and its position, tlast marks the final
// byte of a line and every error item.
// Throughput: one input item per cycle while a line is being gathered. When a
// line end completes a line, the input stalls until the back end has read the
// whole line from the line store, one byte per cycle through its registered read
// port while the receiver takes the bytes. Errors pass through a two entry
// command queue and do not stall input unless it is full.
// With the output register free, an error item moves from the queue into the
// output register; a line's first byte passes the queue, the back end's drain
// state, the line store's read register and the output register in that order.
// Reset clears the parse mode, fill count, queue and output register; the line
// store needs no clearing. When the receiver stalls, the output register holds its
// item, the queue fills, and the input is held off in turn; nothing is dropped.
`timescale 1ns / 1ps
module shell_command_line_assembler_top
	import scla_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] line_byte, [13:8] byte_position, [15:14] zero
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast    // last_of_line
);

	localparam int FW = $clog2(LINE_BUFFER_BYTES);

	cmd_slot_t         push, head;
	logic              fifo_full, has_line, pop, draining, line_busy;
	logic              ram_we, ram_re;
	logic [FW-1:0]     ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata, m_byte;
	logic [POS_W-1:0]  m_pos;

	// The front may not write the store while a finished line waits or drains.
	assign line_busy = has_line || draining;

	scla_front #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.fifo_full (fifo_full),
		.line_busy (line_busy),
		.push      (push),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	scla_ram #(
		.WIDTH (8),
		.DEPTH (LINE_BUFFER_BYTES)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	scla_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.full     (fifo_full),
		.has_line (has_line)
	);

	scla_back #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.draining  (draining),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_byte    (m_byte),
		.m_pos     (m_pos),
		.m_tlast   (m_tlast)
	);

	assign m_tdata = {2'b00, m_pos, m_byte};

endmodule

/* rtl/core/scla_checker.sv */
// Port level checker for the command line assembler, bound to the top level.
`timescale 1ns / 1ps
`include "shell_command_line_assembler_top_assert.svh"
module scla_checker
	import scla_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	logic [7:0] obyte;
	logic [5:0] opos;

	assign obyte = m_tdata[7:0];
	assign opos = m_tdata[13:8];

	`SCLA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result item changed")

	`SCLA_ASSERT_SAME(a_err_shape, m_tvalid && (m_tuser != KIND_LINE), m_tlast && (m_tdata == 16'h0000), "error item without last flag or with data")

	`SCLA_ASSERT_SAME(a_line_char, m_tvalid && (m_tuser == KIND_LINE), ((obyte >= 8'h20) && (obyte <= 8'h7E)) || (obyte == 8'h09) || (obyte == 8'h0B) || (obyte == 8'h0C), "line byte is a line end or control byte")

	`SCLA_ASSERT_SAME(a_line_pos, m_tvalid && (m_tuser == KIND_LINE), 32'(opos) <= LINE_BUFFER_BYTES - 2, "line byte position beyond the store")

endmodule

bind shell_command_line_assembler_top scla_checker #(
	.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
) u_scla_checker (.*);

/* verif/shell_command_line_assembler_top_tb.sv */
// Self-checking testbench for the console command line assembler: directed table, then random lines.
`timescale 1ns / 1ps
module shell_command_line_assembler_top_tb
	import scla_pkg::*;
;

	localparam int LINE_BYTES   = 64;
	localparam int RANDOM_ITEMS = 430;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 300000;

	// How an item's results are checked: by the predictor, as none, or as one error.
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_ERROR
	} chk_t;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		chk_t       chk;
		kind_t      err_kind;
	} console_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [5:0] pos;
		logic       last;
	} console_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic [0:0]  s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	shell_command_line_assembler_top #(
		.LINE_BUFFER_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Directed items: errors and silent cases are typed in, line contents are predicted.
	console_item_t directed_tbl [0:27] = '{
		'{OPC_RX_BYTE,   CH_LF,       CHK_NONE,    KIND_LINE},     // line end right after reset
		'{OPC_RX_BYTE,   8'h00,       CHK_ERROR,   KIND_BAD_BYTE},
		'{OPC_RX_BYTE,   8'h78,       CHK_NONE,    KIND_LINE},     // dropped while discarding
		'{OPC_RX_BYTE,   CH_CR,       CHK_NONE,    KIND_LINE},
		'{OPC_RX_BYTE,   8'hFF,       CHK_ERROR,   KIND_BAD_BYTE},
		'{OPC_RX_BYTE,   CH_LF,       CHK_NONE,    KIND_LINE},
		'{OPC_RX_BYTE,   8'h7F,       CHK_ERROR,   KIND_BAD_BYTE},
		'{OPC_RX_BYTE,   CH_LF,       CHK_NONE,    KIND_LINE},
		'{OPC_RX_BYTE,   CH_SPACE,    CHK_PREDICT, KIND_LINE},     // leading space dropped
		'{OPC_RX_BYTE,   CH_PRINT_LO, CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_TAB,      CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_SPACE,    CHK_PREDICT, KIND_LINE},     // run collapses
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},     // empty pair removed
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_SPACE,    CHK_PREDICT, KIND_LINE},     // kept inside quotes
		'{OPC_RX_BYTE,   CH_PRINT_HI, CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_SPACE,    CHK_PREDICT, KIND_LINE},     // trailing space stripped
		'{OPC_RX_BYTE,   CH_CR,       CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},     // empty pair leaves start mode
		'{OPC_RX_BYTE,   CH_LF,       CHK_NONE,    KIND_LINE},
		'{OPC_RX_BYTE,   CH_QUOTE,    CHK_PREDICT, KIND_LINE},
		'{OPC_RX_BYTE,   CH_LF,       CHK_ERROR,   KIND_QUOTE_EOL},
		'{OPC_RX_BYTE,   8'h61,       CHK_PREDICT, KIND_LINE},
		'{OPC_LINK_IDLE, 8'hFF,       CHK_NONE,    KIND_LINE},     // partial line forgotten
		'{OPC_RX_BYTE,   CH_LF,       CHK_NONE,    KIND_LINE}
	};

	int unsigned SEND_IDLE_PCT  [0:3] = '{0, 75, 0, 10};
	int unsigned RECV_STALL_PCT [0:3] = '{0, 0, 75, 10};

	console_item_t   console_items[$];
	console_result_t pending_results[$];
	console_result_t predicted[$];

	// Parser copy kept by the testbench.
	mode_t       cons_mode;
	int          fill_cnt;
	logic [7:0]  line_buf [0:LINE_BYTES-1];

	int in_taken   = 0;
	int fail_count = 0;
	int phase      = 0;
	int cycle_count;
	logic hold_off = 1'b0;

	function automatic void add_result(kind_t k, logic [7:0] c, logic [5:0] p, logic l);
		console_result_t r;
		r.kind = k;
		r.ch   = c;
		r.pos  = p;
		r.last = l;
		predicted.push_back(r);
	endfunction

	function automatic void parse_console_byte(logic op, logic [7:0] rx);
		logic       eol, ws, gr;
		logic [7:0] c;
		int         i;
		c = rx;
		if (op == OPC_LINK_IDLE) begin
			cons_mode = MODE_START;
			fill_cnt  = 0;
			return;
		end
		eol = (c == CH_LF) || (c == CH_CR);
		ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CTRL_WS_HI);
		gr  = (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI);
		if (cons_mode == MODE_DISCARD) begin
			if (eol)
				cons_mode = MODE_START;
			return;
		end
		if (!ws && !gr) begin
			add_result(KIND_BAD_BYTE, 8'h00, 6'd0, 1'b1);
			cons_mode = MODE_DISCARD;
			fill_cnt  = 0;
			return;
		end
		if (eol) begin
			if (cons_mode == MODE_QUOTE) begin
				add_result(KIND_QUOTE_EOL, 8'h00, 6'd0, 1'b1);
			end else if (cons_mode != MODE_START) begin
				if (fill_cnt != 0 && line_buf[fill_cnt-1] == CH_SPACE)
					fill_cnt--;
				for (i = 0; i < fill_cnt; i++)
					add_result(KIND_LINE, line_buf[i], i[5:0], (i + 1 == fill_cnt));
			end
			cons_mode = MODE_START;
			fill_cnt  = 0;
			return;
		end
		if (ws) begin
			if (cons_mode == MODE_START)
				return;
			if (cons_mode != MODE_QUOTE) begin
				if (fill_cnt != 0 && line_buf[fill_cnt-1] == CH_SPACE)
					return;
				c = CH_SPACE;
			end
		end
		if (c == CH_QUOTE) begin
			if (cons_mode == MODE_QUOTE) begin
				// A closing quote right after the opening one cancels the pair.
				if (fill_cnt != 0 && line_buf[fill_cnt-1] == CH_QUOTE) begin
					fill_cnt--;
					cons_mode = (fill_cnt != 0) ? MODE_PROC : MODE_START;
					return;
				end
				cons_mode = (fill_cnt != 0) ? MODE_PROC : MODE_START;
			end else begin
				cons_mode = MODE_QUOTE;
			end
		end
		if (fill_cnt >= LINE_BYTES - 1) begin
			add_result(KIND_OVERFLOW, 8'h00, 6'd0, 1'b1);
			cons_mode = MODE_DISCARD;
			fill_cnt  = 0;
			return;
		end
		line_buf[fill_cnt] = c;
		fill_cnt++;
		if (cons_mode == MODE_START)
			cons_mode = MODE_PROC;
	endfunction

	task automatic queue_rx(logic op, logic [7:0] c);
		console_item_t it;
		it.op       = op;
		it.ch       = c;
		it.chk      = CHK_PREDICT;
		it.err_kind = KIND_LINE;
		console_items.push_back(it);
	endtask

	// Printable byte that is neither a quote nor whitespace.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
		return (c == CH_QUOTE) ? CH_PRINT_HI : c;
	endfunction

	function automatic logic [7:0] line_char();
		int unsigned r;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		if (r < 55)
			return plain_char();
		if (r < 70)
			return CH_SPACE;
		if (r < 78) begin
			c = 8'($urandom_range(CH_TAB, CH_CTRL_WS_HI));
			return (c == CH_LF || c == CH_CR) ? CH_TAB : c;
		end
		if (r < 92)
			return CH_QUOTE;
		return plain_char();
	endfunction

	function automatic logic [7:0] bad_char();
		case ($urandom_range(0, 2))
			0:       return 8'($urandom_range(0, CH_TAB - 1));
			1:       return 8'($urandom_range(CH_CTRL_WS_HI + 1, CH_SPACE - 1));
			default: return 8'($urandom_range(CH_PRINT_HI + 1, 255));
		endcase
	endfunction

	task automatic queue_chars(int n);
		int i;
		for (i = 0; i < n; i++)
			queue_rx(OPC_RX_BYTE, line_char());
	endtask

	task automatic queue_line(int len, bit plain);
		int i;
		if (!plain && $urandom_range(0, 3) == 0)
			queue_rx(OPC_RX_BYTE, CH_SPACE);
		for (i = 0; i < len; i++)
			queue_rx(OPC_RX_BYTE, plain ? plain_char() : line_char());
		queue_rx(OPC_RX_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
	endtask

	task automatic build_console_stimulus();
		int          i;
		int unsigned r;
		for (i = 0; i < $size(directed_tbl); i++)
			console_items.push_back(directed_tbl[i]);
		// The fullest line the store can hold, then one byte too many.
		queue_line(LINE_BYTES - 1, 1'b1);
		queue_line(LINE_BYTES, 1'b1);
		while (console_items.size() < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				queue_line($urandom_range(1, 12), 1'b0);
			end else if (r < 68) begin
				queue_line($urandom_range(LINE_BYTES - 9, LINE_BYTES + 6), 1'b0);
			end else if (r < 78) begin
				for (i = $urandom_range(1, 5); i > 0; i--)
					queue_rx(OPC_RX_BYTE, 8'($urandom_range(0, 255)));
			end else if (r < 86) begin
				// Bad byte in mid line; the rest is discarded up to the line end.
				queue_chars($urandom_range(0, 6));
				queue_rx(OPC_RX_BYTE, bad_char());
				queue_chars($urandom_range(0, 4));
				queue_rx(OPC_RX_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
			end else if (r < 93) begin
				queue_chars($urandom_range(0, 8));
				queue_rx(OPC_LINK_IDLE, 8'($urandom_range(0, 255)));
			end else begin
				queue_chars($urandom_range(0, 4));
				queue_rx(OPC_RX_BYTE, CH_QUOTE);
				queue_chars($urandom_range(0, 4));
				queue_rx(OPC_RX_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results are compared first, then the accepted item adds its expectations.
	always @(posedge clk) begin : check_results
		console_result_t want;
		console_item_t   it;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing pending: kind %0d data %h last %b",
						m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata[7:0] !== want.ch) begin
						$error("line_byte: expected %h, actual %h", want.ch, m_tdata[7:0]);
						fail_count++;
					end
					if (m_tdata[13:8] !== want.pos) begin
						$error("byte_position: expected %0d, actual %0d", want.pos, m_tdata[13:8]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_line: expected %b, actual %b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predicted.delete();
				parse_console_byte(s_tuser[0], s_tdata);
				it = console_items[in_taken];
				case (it.chk)
					CHK_PREDICT: begin
						foreach (predicted[i])
							pending_results.push_back(predicted[i]);
					end
					CHK_ERROR: begin
						want.kind = it.err_kind;
						want.ch   = 8'h00;
						want.pos  = 6'd0;
						want.last = 1'b1;
						pending_results.push_back(want);
					end
					default: begin
					end
				endcase
				in_taken++;
			end
		end
	end

	// Sender: a held item stays on the bus until taken; idling follows the phase.
	initial begin : drive_console
		int idx;
		bit taken;
		idx = 0;
		wait (arst_n === 1'b1);
		while (idx < console_items.size()) begin
			@(posedge clk);
			taken = s_tvalid && s_tready;
			if (taken)
				idx++;
			if (idx == console_items.size()) begin
				s_tvalid <= 1'b0;
			end else if (!s_tvalid || taken) begin
				phase = idx * 4 / console_items.size();
				if ($urandom_range(0, 99) < SEND_IDLE_PCT[phase]) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= console_items[idx].ch;
					s_tuser  <= console_items[idx].op;
				end
			end
		end
	end

	initial begin : drive_ready
		forever begin
			@(posedge clk);
			m_tready <= !hold_off && ($urandom_range(0, 99) >= RECV_STALL_PCT[phase]);
		end
	end

	// A long receiver hold-off while the sender keeps going, so a line backs up
	// into the queue and the input stalls.
	initial begin : long_hold_off
		wait (in_taken >= 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** shell_command_line_assembler_top: FAILED **");
		$finish;
	end

	initial begin : run_control
		cons_mode = MODE_START;
		fill_cnt  = 0;
		build_console_stimulus();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (!(in_taken == console_items.size() && pending_results.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** shell_command_line_assembler_top: PASSED **");
		else
			$display("** shell_command_line_assembler_top: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/scla_pkg.sv
rtl/core/scla_ram.sv
rtl/core/scla_front.sv
rtl/core/scla_cmd_fifo.sv
rtl/core/scla_back.sv
rtl/core/shell_command_line_assembler_top.sv
rtl/core/scla_checker.sv
verif/shell_command_line_assembler_top_tb.sv
